// ===== src/rlg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray / line geometry package
// Widths, operation and result codes, register indexes and the word types
// of the ray / line geometry unit.
// ----------------------------------------------------------------------------
package rlg_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = COORD_W - 1;
    localparam int DIST_W    = COORD_W - 1;
    localparam int REG_IDX_W = 3;

    localparam logic [1:0] OP_SIDE   = 2'd0;
    localparam logic [1:0] OP_RAY    = 2'd1;
    localparam logic [1:0] OP_NORMAL = 2'd2;

    localparam logic [1:0] SIDE_ON  = 2'd0;
    localparam logic [1:0] SIDE_POS = 2'd1;
    localparam logic [1:0] SIDE_NEG = 2'd2;

    localparam logic [1:0] HIT_YES      = 2'd0;
    localparam logic [1:0] HIT_PARALLEL = 2'd1;
    localparam logic [1:0] HIT_BEHIND   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIDE_TOL     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PARALLEL_TOL = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ONTO_TOL     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CHECK_ENABLE = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [1:0] op;
        coord_t     pos_x;
        coord_t     pos_y;
        coord_t     dir_x;
        coord_t     dir_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        side_code;
        logic [1:0]        hit_code;
        logic [DIST_W-1:0] distance;
        coord_t            hit_x;
        coord_t            hit_y;
        logic              normal_ok;
        coord_t            normal_out_x;
        coord_t            normal_out_y;
    } out_word_t;

endpackage
`default_nettype wire

// ===== src/ray_line_geometry_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray / line geometry unit
// Side relation, ray intersection and normal query against one 2D line.
// ----------------------------------------------------------------------------
// Use of the block:
// The line (origin, normal) and the tolerances are written through the plain
// write port (cfg_write, cfg_index, cfg_data); the user must do so only while
// no word is in flight, which the block itself does not enforce. Input words
// arrive on in_valid / in_stall / in_word and each one yields exactly one
// output word on out_valid / out_stall / out_word, in order. The datapath is
// a pipeline of 39 register stages plus the output register, and one word
// can be taken in every cycle while in_stall is low. The depth is set by
// the ray distance quotient: a restoring divider, one quotient bit per
// stage (31 stages), followed by the hit point multiply and saturation.
// When the receiver stalls, the output register holds its word and a skid
// register catches the next one; only while the skid register is full is
// in_stall raised and the whole pipeline frozen, so nothing is lost.
// Reset empties the pipeline and loads the register reset values: origin
// (0, 0), normal (1.0, 0), all tolerances zero and the on-line check off.
// ----------------------------------------------------------------------------
module ray_line_geometry_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rlg_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [rlg_pkg::COORD_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rlg_pkg::in_word_t              in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rlg_pkg::out_word_t             out_word
);
    import rlg_pkg::*;

    // Derived widths of the datapath.
    localparam int KW     = COORD_W + 1;          // point minus origin
    localparam int PKW    = COORD_W + KW;         // normal times offset
    localparam int KSW    = PKW + 1;              // dot product k
    localparam int PLW    = 2 * COORD_W;          // direction times normal
    localparam int L1W    = PLW + 1;              // dot product l1
    localparam int NUMW   = KSW + FRAC_BITS;      // scaled dividend
    localparam int DIVW   = L1W + DIST_W;         // widest shifted divisor
    localparam int T2W    = 2 * TOL_W;            // tolerance squared
    localparam int SUMW   = 2 * COORD_W + 1;      // sum of offset squares
    localparam int HW     = COORD_W;              // half width of |k|
    localparam int SQW    = 2 * HW;               // |k| that can be squared
    localparam int WIDE   = 2 * SQW;              // square comparison width
    localparam int TL     = TOL_W;
    localparam int TH     = T2W - TL;
    localparam int SL     = COORD_W;
    localparam int SH     = SUMW - SL;
    localparam int STEPS  = DIST_W;
    localparam int NST    = 6 + STEPS + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    coord_t             origin_x_reg, origin_y_reg, normal_x_reg, normal_y_reg;
    logic [TOL_W-1:0]   side_tol_reg, par_tol_reg, onto_tol_reg;
    logic               check_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            normal_x_reg <= COORD_W'(1) << FRAC_BITS;
            normal_y_reg <= '0;
            side_tol_reg <= '0;
            par_tol_reg  <= '0;
            onto_tol_reg <= '0;
            check_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg <= cfg_data;
                REG_NORMAL_X:     normal_x_reg <= cfg_data;
                REG_NORMAL_Y:     normal_y_reg <= cfg_data;
                REG_SIDE_TOL:     side_tol_reg <= cfg_data[TOL_W-1:0];
                REG_PARALLEL_TOL: par_tol_reg  <= cfg_data[TOL_W-1:0];
                REG_ONTO_TOL:     onto_tol_reg <= cfg_data[TOL_W-1:0];
                REG_CHECK_ENABLE: check_en_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] op;
        coord_t     px;
        coord_t     py;
        coord_t     dx;
        coord_t     dy;
    } base_t;

    typedef struct packed {
        base_t               b;
        logic signed [KW-1:0] kx;
        logic signed [KW-1:0] ky;
        logic [COORD_W-1:0]  ukx;
        logic [COORD_W-1:0]  uky;
    } st1_t;

    typedef struct packed {
        base_t                 b;
        logic signed [PKW-1:0] pkx;
        logic signed [PKW-1:0] pky;
        logic signed [PLW-1:0] plx;
        logic signed [PLW-1:0] ply;
        logic [PLW-1:0]        sqx;
        logic [PLW-1:0]        sqy;
        logic [T2W-1:0]        t2;
    } st2_t;

    typedef struct packed {
        base_t                 b;
        logic signed [KSW-1:0] k;
        logic signed [L1W-1:0] l1;
        logic [SUMW-1:0]       s;
        logic [T2W-1:0]        t2;
    } st3_t;

    typedef struct packed {
        base_t           b;
        logic [1:0]      side;
        logic [1:0]      hit;
        logic [KSW-1:0]  absk;
        logic [L1W-1:0]  a1;
        logic [SUMW-1:0] s;
        logic [T2W-1:0]  t2;
    } st4_t;

    typedef struct packed {
        base_t            b;
        logic [1:0]       side;
        logic [1:0]       hit;
        logic [KSW-1:0]   absk;
        logic [L1W-1:0]   a1;
        logic [2*HW-1:0]  mll;
        logic [2*HW-1:0]  mlh;
        logic [2*HW-1:0]  mhh;
        logic [TL+SL-1:0] rll;
        logic [TL+SH-1:0] rlh;
        logic [TH+SL-1:0] rhl;
        logic [TH+SH-1:0] rhh;
    } st5_t;

    typedef struct packed {
        base_t          b;
        logic [1:0]     side;
        logic [1:0]     hit;
        logic [KSW-1:0] absk;
        logic [L1W-1:0] a1;
        logic [WIDE-1:0] lhs;
        logic [WIDE-1:0] rhs;
    } st6_t;

    typedef struct packed {
        base_t      b;
        logic [1:0] side;
        logic [1:0] hit;
        logic       sat;
        logic       nok;
    } carry_t;

    typedef struct packed {
        carry_t          c;
        logic [NUMW-1:0] rem;
        logic [L1W-1:0]  a1;
        logic [DIST_W-1:0] q;
    } div_t;

    typedef struct packed {
        carry_t                c;
        logic [DIST_W-1:0]     q;
        logic signed [PLW-1:0] hx_p;
        logic signed [PLW-1:0] hy_p;
    } st8_t;

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves whenever the skid register is empty
    // ------------------------------------------------------------------
    logic            en;
    logic [NST-1:0]  pipe_v_reg;
    logic            out_v_reg, skid_v_reg;
    out_word_t       out_reg, skid_reg, res;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_v_reg <= '0;
        end
        else if (en)
        begin
            pipe_v_reg <= {pipe_v_reg[NST-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from the origin and its magnitude
    // ------------------------------------------------------------------
    st1_t                  st1_reg;
    logic signed [KW-1:0]  dpx, dnx, dpy, dny;

    assign dpx = KW'(in_word.pos_x) - KW'(origin_x_reg);
    assign dnx = KW'(origin_x_reg) - KW'(in_word.pos_x);
    assign dpy = KW'(in_word.pos_y) - KW'(origin_y_reg);
    assign dny = KW'(origin_y_reg) - KW'(in_word.pos_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg.b.op <= in_word.op;
            st1_reg.b.px <= in_word.pos_x;
            st1_reg.b.py <= in_word.pos_y;
            st1_reg.b.dx <= in_word.dir_x;
            st1_reg.b.dy <= in_word.dir_y;
            st1_reg.kx   <= dpx;
            st1_reg.ky   <= dpy;
            st1_reg.ukx  <= dpx[KW-1] ? dnx[COORD_W-1:0] : dpx[COORD_W-1:0];
            st1_reg.uky  <= dpy[KW-1] ? dny[COORD_W-1:0] : dpy[COORD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products of the dot products and the squares
    // ------------------------------------------------------------------
    st2_t                  st2_reg;
    logic signed [PKW-1:0] pkx_c, pky_c;
    logic signed [PLW-1:0] plx_c, ply_c;

    assign pkx_c = $signed(normal_x_reg) * $signed(st1_reg.kx);
    assign pky_c = $signed(normal_y_reg) * $signed(st1_reg.ky);
    assign plx_c = $signed(st1_reg.b.dx) * $signed(normal_x_reg);
    assign ply_c = $signed(st1_reg.b.dy) * $signed(normal_y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st2_reg.b   <= st1_reg.b;
            st2_reg.pkx <= pkx_c;
            st2_reg.pky <= pky_c;
            st2_reg.plx <= plx_c;
            st2_reg.ply <= ply_c;
            st2_reg.sqx <= PLW'(st1_reg.ukx) * PLW'(st1_reg.ukx);
            st2_reg.sqy <= PLW'(st1_reg.uky) * PLW'(st1_reg.uky);
            st2_reg.t2  <= T2W'(onto_tol_reg) * T2W'(onto_tol_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dot products k = n.(p - o) and l1 = d.n
    // ------------------------------------------------------------------
    st3_t st3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_reg.b  <= st2_reg.b;
            st3_reg.k  <= KSW'($signed(st2_reg.pkx)) + KSW'($signed(st2_reg.pky));
            st3_reg.l1 <= L1W'($signed(st2_reg.plx)) + L1W'($signed(st2_reg.ply));
            st3_reg.s  <= SUMW'(st2_reg.sqx) + SUMW'(st2_reg.sqy);
            st3_reg.t2 <= st2_reg.t2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: side and hit verdicts, magnitudes
    // ------------------------------------------------------------------
    st4_t                  st4_reg;
    logic signed [KSW-1:0] side_t;
    logic signed [L1W-1:0] par_t;
    logic                  side_on, par, kneg, kzero, l1neg, behind;
    logic [1:0]            side_c, hit_c;

    assign side_t = $signed({{(KSW-TOL_W-FRAC_BITS){1'b0}}, side_tol_reg,
                             {FRAC_BITS{1'b0}}});
    assign par_t  = $signed({{(L1W-TOL_W-FRAC_BITS){1'b0}}, par_tol_reg,
                             {FRAC_BITS{1'b0}}});
    assign side_on = (st3_reg.k <= side_t) && (st3_reg.k >= -side_t);
    assign par     = (st3_reg.l1 <= par_t) && (st3_reg.l1 >= -par_t);
    assign kneg    = st3_reg.k[KSW-1];
    assign kzero   = (st3_reg.k == '0);
    assign l1neg   = st3_reg.l1[L1W-1];
    // l0 = -k, so the ray points away from the line when k and l1 agree in sign.
    assign behind  = kzero || (kneg == l1neg);

    always_comb
    begin
        side_c = SIDE_ON;
        hit_c  = HIT_YES;
        if (st3_reg.b.op == OP_SIDE)
        begin
            if (side_on)
                side_c = SIDE_ON;
            else if (kneg)
                side_c = SIDE_NEG;
            else
                side_c = SIDE_POS;
        end
        if (st3_reg.b.op == OP_RAY)
        begin
            if (par)
                hit_c = HIT_PARALLEL;
            else if (behind)
                hit_c = HIT_BEHIND;
            else
                hit_c = HIT_YES;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st4_reg.b    <= st3_reg.b;
            st4_reg.side <= side_c;
            st4_reg.hit  <= hit_c;
            st4_reg.absk <= kneg ? KSW'(-st3_reg.k) : KSW'(st3_reg.k);
            st4_reg.a1   <= l1neg ? L1W'(-st3_reg.l1) : L1W'(st3_reg.l1);
            st4_reg.s    <= st3_reg.s;
            st4_reg.t2   <= st3_reg.t2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of |k|^2 and t^2 * (kx^2 + ky^2)
    // ------------------------------------------------------------------
    st5_t           st5_reg;
    logic [HW-1:0]  a_l, a_h;
    logic [TL-1:0]  t_l;
    logic [TH-1:0]  t_h;
    logic [SL-1:0]  s_l;
    logic [SH-1:0]  s_h;

    assign a_l = st4_reg.absk[HW-1:0];
    assign a_h = st4_reg.absk[2*HW-1:HW];
    assign t_l = st4_reg.t2[TL-1:0];
    assign t_h = st4_reg.t2[T2W-1:TL];
    assign s_l = st4_reg.s[SL-1:0];
    assign s_h = st4_reg.s[SUMW-1:SL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st5_reg.b    <= st4_reg.b;
            st5_reg.side <= st4_reg.side;
            st5_reg.hit  <= st4_reg.hit;
            st5_reg.absk <= st4_reg.absk;
            st5_reg.a1   <= st4_reg.a1;
            st5_reg.mll  <= (2*HW)'(a_l) * (2*HW)'(a_l);
            st5_reg.mlh  <= (2*HW)'(a_l) * (2*HW)'(a_h);
            st5_reg.mhh  <= (2*HW)'(a_h) * (2*HW)'(a_h);
            st5_reg.rll  <= (TL+SL)'(t_l) * (TL+SL)'(s_l);
            st5_reg.rlh  <= (TL+SH)'(t_l) * (TL+SH)'(s_h);
            st5_reg.rhl  <= (TH+SL)'(t_h) * (TH+SL)'(s_l);
            st5_reg.rhh  <= (TH+SH)'(t_h) * (TH+SH)'(s_h);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sums of the partial products
    // ------------------------------------------------------------------
    st6_t st6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st6_reg.b    <= st5_reg.b;
            st6_reg.side <= st5_reg.side;
            st6_reg.hit  <= st5_reg.hit;
            st6_reg.absk <= st5_reg.absk;
            st6_reg.a1   <= st5_reg.a1;
            st6_reg.lhs  <= (WIDE'(st5_reg.mhh) << (2*HW))
                          + (WIDE'(st5_reg.mlh) << (HW+1))
                          + WIDE'(st5_reg.mll);
            st6_reg.rhs  <= (WIDE'(st5_reg.rhh) << (TL+SL))
                          + (WIDE'(st5_reg.rhl) << TL)
                          + (WIDE'(st5_reg.rlh) << SL)
                          + WIDE'(st5_reg.rll);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: on-line verdict, saturation test and divider set-up
    // ------------------------------------------------------------------
    div_t              st7_reg;
    div_t              div_stage [0:STEPS];
    logic [NUMW-1:0]   num0;
    logic              nok_c, sat_c;

    assign num0  = {st6_reg.absk, {FRAC_BITS{1'b0}}};
    assign sat_c = DIVW'(num0) >= (DIVW'(st6_reg.a1) << STEPS);
    assign nok_c = !check_en_reg
                || ((st6_reg.absk[KSW-1:SQW] == '0) && (st6_reg.rhs >= st6_reg.lhs));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st7_reg.c.b    <= st6_reg.b;
            st7_reg.c.side <= st6_reg.side;
            st7_reg.c.hit  <= st6_reg.hit;
            st7_reg.c.sat  <= sat_c;
            st7_reg.c.nok  <= nok_c;
            st7_reg.rem    <= num0;
            st7_reg.a1     <= st6_reg.a1;
            st7_reg.q      <= '0;
        end
    end

    assign div_stage[0] = st7_reg;

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    for (genvar j = 0; j < STEPS; j++)
    begin : g_div
        localparam int BIT = STEPS - 1 - j;
        div_t              stage_reg;
        logic [DIVW-1:0]   dsh;
        logic              ge;

        assign dsh = DIVW'(div_stage[j].a1) << BIT;
        assign ge  = DIVW'(div_stage[j].rem) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg.c   <= div_stage[j].c;
                stage_reg.a1  <= div_stage[j].a1;
                stage_reg.rem <= ge ? div_stage[j].rem - dsh[NUMW-1:0]
                                    : div_stage[j].rem;
                stage_reg.q   <= div_stage[j].q | (DIST_W'(ge) << BIT);
            end
        end

        assign div_stage[j+1] = stage_reg;
    end

    // ------------------------------------------------------------------
    // Stage H1: saturated distance and the direction products
    // ------------------------------------------------------------------
    st8_t               h1_reg;
    div_t               dlast;
    logic [DIST_W-1:0]  qf;

    assign dlast = div_stage[STEPS];
    assign qf    = dlast.c.sat ? '1 : dlast.q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg.c    <= dlast.c;
            h1_reg.q    <= qf;
            h1_reg.hx_p <= $signed(dlast.c.b.dx) * $signed({1'b0, qf});
            h1_reg.hy_p <= $signed(dlast.c.b.dy) * $signed({1'b0, qf});
        end
    end

    // ------------------------------------------------------------------
    // Output word: hit point, masking of unused fields
    // ------------------------------------------------------------------
    function automatic coord_t sat_coord(input logic signed [PLW:0] v);
        coord_t r;
        if ((v[PLW:COORD_W-1] == '0) || (v[PLW:COORD_W-1] == '1))
            r = v[COORD_W-1:0];
        else if (v[PLW])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

    logic signed [PLW:0] hx_sum, hy_sum;
    logic                ray_ok, nrm_ok;

    assign hx_sum = (PLW+1)'($signed(h1_reg.hx_p) >>> FRAC_BITS)
                  + (PLW+1)'($signed(h1_reg.c.b.px));
    assign hy_sum = (PLW+1)'($signed(h1_reg.hy_p) >>> FRAC_BITS)
                  + (PLW+1)'($signed(h1_reg.c.b.py));
    assign ray_ok = (h1_reg.c.b.op == OP_RAY) && (h1_reg.c.hit == HIT_YES);
    assign nrm_ok = (h1_reg.c.b.op == OP_NORMAL) && h1_reg.c.nok;

    always_comb
    begin
        res.side_code    = h1_reg.c.side;
        res.hit_code     = h1_reg.c.hit;
        res.distance     = ray_ok ? h1_reg.q : '0;
        res.hit_x        = ray_ok ? sat_coord(hx_sum) : '0;
        res.hit_y        = ray_ok ? sat_coord(hy_sum) : '0;
        res.normal_ok    = nrm_ok;
        res.normal_out_x = nrm_ok ? normal_x_reg : '0;
        res.normal_out_y = nrm_ok ? normal_y_reg : '0;
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (en)
        begin
            if (!out_v_reg || !out_stall)
                out_v_reg <= pipe_v_reg[NST-1];
            else if (pipe_v_reg[NST-1])
                skid_v_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!out_v_reg || !out_stall)
                out_reg <= res;
            else
                skid_reg <= res;
        end
        else if (!out_stall)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_word  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && out_stall))
        else $error("skid register filled without a stalled output word");

    a_dist_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.hit_code != HIT_YES)) |->
            ((out_word.distance == '0) && (out_word.hit_x == '0)
             && (out_word.hit_y == '0)))
        else $error("hit fields set without an intersection");

    a_normal_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.normal_ok) |->
            ((out_word.normal_out_x == '0) && (out_word.normal_out_y == '0)))
        else $error("normal returned for a rejected query");

endmodule
`default_nettype wire

// ===== bench/rlg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray / line geometry checker
// Watches the configuration port and both word channels, predicts every
// output word from the accepted input word and compares field by field.
// ----------------------------------------------------------------------------
module rlg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [rlg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [rlg_pkg::COORD_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  rlg_pkg::in_word_t  in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  rlg_pkg::out_word_t out_word,
    output int                 errors,
    output int                 pending
);
    import rlg_pkg::*;

    coord_t            line_ox, line_oy, line_nx, line_ny;
    logic [TOL_W-1:0]  tol_side, tol_par, tol_onto;
    logic              chk_on;
    out_word_t         expected_words[$];

    function automatic coord_t clamp_coord(logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -128'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic out_word_t geometry_of(in_word_t w);
        out_word_t r;
        logic signed [127:0] px, py, dx, dy, kx, ky, nx, ny;
        logic signed [127:0] k, ka, l0, l1, a1, num, tq, qs;
        logic [127:0] ad, lhs, rhs, t2, ux, uy;
        logic [63:0] q;
        r = '0;
        px = w.pos_x;
        py = w.pos_y;
        dx = w.dir_x;
        dy = w.dir_y;
        nx = line_nx;
        ny = line_ny;
        kx = px - 128'(line_ox);
        ky = py - 128'(line_oy);
        kx = px - $signed(line_ox);
        ky = py - $signed(line_oy);
        k = nx * kx + ny * ky;
        ka = (k < 0) ? -k : k;
        case (w.op)
            OP_SIDE:
            begin
                tq = $signed({97'b0, tol_side}) <<< FRAC_BITS;
                if (tq >= ka)
                    r.side_code = SIDE_ON;
                else
                    r.side_code = (k < 0) ? SIDE_NEG : SIDE_POS;
            end
            OP_RAY:
            begin
                l1 = dx * nx + dy * ny;
                a1 = (l1 < 0) ? -l1 : l1;
                tq = $signed({97'b0, tol_par}) <<< FRAC_BITS;
                l0 = -k;
                if (tq >= a1)
                    r.hit_code = HIT_PARALLEL;
                else if (l0 == 0 || ((l0 < 0) != (l1 < 0)))
                    r.hit_code = HIT_BEHIND;
                else
                begin
                    num = ka <<< FRAC_BITS;
                    if (num >= (a1 <<< (COORD_W - 1)))
                        q = 64'h7FFFFFFF;
                    else
                        q = 64'(num / a1);
                    qs = $signed({64'b0, q});
                    r.hit_code = HIT_YES;
                    r.distance = q[DIST_W-1:0];
                    r.hit_x = clamp_coord(((dx * qs) >>> FRAC_BITS) + px);
                    r.hit_y = clamp_coord(((dy * qs) >>> FRAC_BITS) + py);
                end
            end
            OP_NORMAL:
            begin
                r.normal_ok = 1'b1;
                if (chk_on)
                begin
                    ad = ka;
                    if (ad[127:64] != 0)
                        r.normal_ok = 1'b0;
                    else
                    begin
                        lhs = ad * ad;
                        t2 = {97'b0, tol_onto};
                        t2 = t2 * t2;
                        ux = (kx < 0) ? -kx : kx;
                        uy = (ky < 0) ? -ky : ky;
                        rhs = t2 * (ux * ux) + t2 * (uy * uy);
                        if (rhs < lhs)
                            r.normal_ok = 1'b0;
                    end
                end
                if (r.normal_ok)
                begin
                    r.normal_out_x = line_nx;
                    r.normal_out_y = line_ny;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            line_ox <= '0;
            line_oy <= '0;
            line_nx <= 32'sd65536;
            line_ny <= '0;
            tol_side <= '0;
            tol_par <= '0;
            tol_onto <= '0;
            chk_on <= 1'b0;
            errors <= 0;
            pending <= 0;
            expected_words.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_words.push_back(geometry_of(in_word));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("output word with no expectation waiting");
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e != out_word)
                    begin
                        errors <= errors + 1;
                        if (e.side_code != out_word.side_code)
                            $error("side_code exp %0d got %0d", e.side_code, out_word.side_code);
                        if (e.hit_code != out_word.hit_code)
                            $error("hit_code exp %0d got %0d", e.hit_code, out_word.hit_code);
                        if (e.distance != out_word.distance)
                            $error("distance exp %0h got %0h", e.distance, out_word.distance);
                        if (e.hit_x != out_word.hit_x)
                            $error("hit_x exp %0h got %0h", e.hit_x, out_word.hit_x);
                        if (e.hit_y != out_word.hit_y)
                            $error("hit_y exp %0h got %0h", e.hit_y, out_word.hit_y);
                        if (e.normal_ok != out_word.normal_ok)
                            $error("normal_ok exp %0d got %0d", e.normal_ok, out_word.normal_ok);
                        if (e.normal_out_x != out_word.normal_out_x)
                            $error("normal_out_x exp %0h got %0h",
                                   e.normal_out_x, out_word.normal_out_x);
                        if (e.normal_out_y != out_word.normal_out_y)
                            $error("normal_out_y exp %0h got %0h",
                                   e.normal_out_y, out_word.normal_out_y);
                    end
                end
            end
            pending <= expected_words.size();
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:     line_ox <= cfg_data;
                    REG_ORIGIN_Y:     line_oy <= cfg_data;
                    REG_NORMAL_X:     line_nx <= cfg_data;
                    REG_NORMAL_Y:     line_ny <= cfg_data;
                    REG_SIDE_TOL:     tol_side <= cfg_data[TOL_W-1:0];
                    REG_PARALLEL_TOL: tol_par <= cfg_data[TOL_W-1:0];
                    REG_ONTO_TOL:     tol_onto <= cfg_data[TOL_W-1:0];
                    REG_CHECK_ENABLE: chk_on <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray / line geometry unit testbench
// Drives directed and random words through the unit under several line and
// tolerance settings, with random gaps and stalls; the checker beside the
// unit predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
    import rlg_pkg::*;

    // This many cycles with no word moving on either channel means the unit has hung.
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 50;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_word;
    int                   errors;
    int                   pending;
    logic                 in_taken;
    logic                 calm;
    int                   stall_hold;
    int                   idle_cycles;

    ray_line_geometry_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    rlg_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Acceptance is recorded at the rising edge and read by the stimulus at
    // the following falling edge, so the sender never races the unit.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls in bursts, except while the stimulus asks for calm.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= gap_len();
        end
    end

    task automatic send_word(input in_word_t w);
        int g;
        in_word <= w;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (!in_taken);
        g = calm ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] dx, input logic [31:0] dy);
        in_word_t w;
        w.op = op;
        w.pos_x = px;
        w.pos_y = py;
        w.dir_x = dx;
        w.dir_y = dy;
        send_word(w);
    endtask

    // Holds the sender until every word in flight has come out.
    task automatic drain_unit();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0 || in_taken)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_line(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] nx, input logic [31:0] ny,
                            input logic [31:0] st, input logic [31:0] pt,
                            input logic [31:0] ot, input logic ce);
        logic [31:0] vals[8];
        vals = '{ox, oy, nx, ny, st, pt, ot, {31'b0, ce}};
        drain_unit();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[REG_IDX_W-1:0];
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] small_val();
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return small_val();
        endcase
    endfunction

    function automatic logic [31:0] any_tol();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    // Random words: coordinates are mostly small, so that queries reach the divider
    // and the on-line check, else extremes or full random; some carry the undefined code.
    task automatic random_words(input int count, input logic [31:0] ox, input logic [31:0] oy);
        logic [1:0] op;
        logic [31:0] px, py;
        for (int i = 0; i < count; i++)
        begin
            calm = (i % 150) < 30;
            if (i == count / 2)
                drain_unit();
            op = ($urandom_range(0, 39) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            px = any_coord();
            py = any_coord();
            if (op == OP_NORMAL && $urandom_range(0, 2) == 0)
            begin
                px = ox;
                py = oy;
            end
            send_op(op, px, py, any_coord(), any_coord());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        logic [31:0] ox, oy;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word = '0;
        calm = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset line: vertical through the origin, normal (1, 0).
        send_op(OP_SIDE, 32'h0, 32'h0, 32'h0, 32'h0);
        send_op(OP_SIDE, ONE, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_op(OP_SIDE, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_op(OP_RAY, -2 * ONE, 32'h0, ONE, 32'h0);
        send_op(OP_RAY, -2 * ONE, ONE, 32'h0, ONE);
        send_op(OP_RAY, 2 * ONE, 32'h0, ONE, 32'h0);
        send_op(OP_RAY, 32'h0, 5 * ONE, ONE, 32'h0);
        send_op(OP_RAY, 32'h8000_0000, 32'h0, 32'h1, 32'h0);
        send_op(OP_RAY, -ONE, 32'h7FFF_0000, ONE, 32'h7FFF_FFFF);
        send_op(OP_RAY, -ONE, 32'h8000_0000, ONE, 32'h8000_0000);
        send_op(OP_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // On-line check enabled with a relative tolerance of one half.
        set_line(32'h0, 32'h0, ONE, 32'h0, ONE, ONE, 32'h0000_8000, 1'b1);
        send_op(OP_NORMAL, 32'h0, 32'h0, 32'h0, 32'h0);
        send_op(OP_NORMAL, 32'h0, 3 * ONE, 32'h0, 32'h0);
        send_op(OP_NORMAL, 3 * ONE, ONE, 32'h0, 32'h0);
        send_op(OP_SIDE, ONE, 32'h0, 32'h0, 32'h0);
        send_op(OP_RAY, -ONE, 32'h0, ONE, 32'h0);

        // Extreme line and largest tolerances.
        set_line(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_op(OP_SIDE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_op(OP_RAY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_NORMAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_op(OP_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);

        // Random phases, each under its own setting; one keeps small tolerances
        // and a short normal so that intersections are common.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                ox = small_val();
                oy = small_val();
                set_line(ox, oy, ONE, ONE, 32'h0, 32'h0, 32'h0, 1'b0);
            end
            else if (phase == 5)
            begin
                ox = 32'h8000_0000;
                oy = 32'h7FFF_FFFF;
                set_line(ox, oy, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
            end
            else
            begin
                ox = any_coord();
                oy = any_coord();
                set_line(ox, oy, any_coord(), any_coord(), any_tol(), any_tol(), any_tol(),
                         1'($urandom_range(0, 1)));
            end
            random_words(175, ox, oy);
        end

        drain_unit();
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
